FILE: design/mstq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstq_pkg: shared types and codes for the message slot transmit queue
// Opcodes, result status codes, controller states and control structs.
// ----------------------------------------------------------------------------
package mstq_pkg;

  // Item opcodes
  localparam logic OP_APPEND   = 1'b0;
  localparam logic OP_TX_READY = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DROP    = 2'd1;
  localparam logic [1:0] STAT_DISCARD = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input beat
    logic issue_rd;  // read slot length and byte at the tail
    logic commit;    // update state and load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_tx;     // captured item is a transmit-ready
    logic out_free;  // result register can take a new beat
  } dp_stat_t;

endpackage

FILE: design/mstq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstq_ctrl: sequencing controller
// Accepts one item, runs the append or the tail read, then commits it.
// ----------------------------------------------------------------------------
module mstq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mstq_pkg::dp_stat_t    stat,
  output mstq_pkg::ctrl_cmd_t   cmd
);
  import mstq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_tx) begin
          state_nxt = ST_READ;
        end else if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.issue_rd = stat.is_tx;
        cmd.commit   = !stat.is_tx && stat.out_free;
      end
      ST_READ: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // A tail read is always issued from the execute step
  a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ($past(state_r) == ST_EXEC || $past(state_r) == ST_READ))
    else $error("read state entered without execute step");

endmodule

FILE: design/mstq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstq_dpath: slot store, ring pointers, counters and result register
// Byte store and length store are single-port-write memories with
// registered reads; all pointer updates happen on the commit command.
// ----------------------------------------------------------------------------
module mstq_dpath #(
  parameter int SLOTS   = 64,
  parameter int MSG_MAX = 96
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_opcode,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_write,
  input  mstq_pkg::ctrl_cmd_t   cmd,
  output mstq_pkg::dp_stat_t    stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_tx_valid,
  output logic                  out_log_valid,
  output logic [7:0]            out_out_byte,
  output logic [1:0]            out_status,
  output logic [6:0]            out_queued_messages,
  output logic [31:0]           out_dropped_total
);
  import mstq_pkg::*;

  localparam int DEPTH = SLOTS * MSG_MAX;
  localparam int SW    = $clog2(SLOTS);
  localparam int OW    = $clog2(MSG_MAX + 1);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int AW    = $clog2(DEPTH);

  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C   = CW'(SLOTS);
  localparam logic [OW-1:0] MSG_MAX_C = OW'(MSG_MAX);
  localparam logic [AW-1:0] MSG_MAX_A = AW'(MSG_MAX);

  // Storage
  logic [7:0]    byte_mem [DEPTH];
  logic [OW-1:0] len_mem  [SLOTS];

  // Captured beat
  logic          op_r;
  logic [7:0]    byte_r;
  logic          last_r;

  // Mode and queue state
  logic          sink_r;
  logic [SW-1:0] head_r,  head_nxt;
  logic [SW-1:0] tail_r,  tail_nxt;
  logic [CW-1:0] cnt_r,   cnt_nxt;
  logic [OW-1:0] fill_r,  fill_nxt;
  logic [OW-1:0] send_r,  send_nxt;
  logic          disc_r,  disc_nxt;
  logic [31:0]   drop_r,  drop_nxt;

  // Registered memory reads
  logic [7:0]    rd_byte_r;
  logic [OW-1:0] rd_len_r;

  // Result register
  logic          out_valid_r;
  logic          res_tx_r,   res_tx_nxt;
  logic          res_log_r,  res_log_nxt;
  logic [7:0]    res_byte_r, res_byte_nxt;
  logic [1:0]    res_st_r,   res_st_nxt;

  // Memory write controls
  logic          byte_we;
  logic          len_we;
  logic [OW-1:0] fill_inc;
  logic [OW-1:0] send_adv;
  logic          have_byte;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_addr = AW'(head_r) * MSG_MAX_A + AW'(fill_r);
  assign rd_addr = AW'(tail_r) * MSG_MAX_A + AW'(send_r);
  assign fill_inc = fill_r + OW'(1);
  assign have_byte = (send_r < rd_len_r);
  assign send_adv = have_byte ? (send_r + OW'(1)) : send_r;

  assign stat.is_tx    = (op_r == OP_TX_READY);
  assign stat.out_free = !out_valid_r || out_ready;

  // Item behavior, applied on commit
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    send_nxt     = send_r;
    disc_nxt     = disc_r;
    drop_nxt     = drop_r;
    byte_we      = 1'b0;
    len_we       = 1'b0;
    res_tx_nxt   = 1'b0;
    res_log_nxt  = 1'b0;
    res_byte_nxt = 8'd0;
    res_st_nxt   = STAT_OK;
    if (op_r == OP_APPEND) begin
      if (sink_r) begin
        // log bypass
        res_log_nxt  = 1'b1;
        res_byte_nxt = byte_r;
      end else if (disc_r) begin
        if (last_r) disc_nxt = 1'b0;
        res_st_nxt = STAT_DISCARD;
      end else if (fill_r == '0 && cnt_r >= SLOTS_C) begin
        // queue full at chunk start
        drop_nxt   = drop_r + 32'd1;
        disc_nxt   = !last_r;
        res_st_nxt = STAT_DROP;
      end else begin
        byte_we = 1'b1;
        if (fill_inc >= MSG_MAX_C || last_r) begin
          len_we   = 1'b1;
          head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + SW'(1);
          cnt_nxt  = cnt_r + CW'(1);
          fill_nxt = '0;
        end else begin
          fill_nxt = fill_inc;
        end
      end
    end else begin
      if (cnt_r == '0) begin
        res_st_nxt = STAT_EMPTY;
      end else begin
        if (send_adv >= rd_len_r) begin
          // slot finished, retire it
          tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + SW'(1);
          cnt_nxt  = cnt_r - CW'(1);
          send_nxt = '0;
        end else begin
          send_nxt = send_adv;
        end
        if (have_byte) begin
          res_tx_nxt   = 1'b1;
          res_byte_nxt = rd_byte_r;
        end else begin
          res_st_nxt = STAT_EMPTY;
        end
      end
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_opcode;
      byte_r <= in_data_byte;
      last_r <= in_end_of_write;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.commit && byte_we) byte_mem[wr_addr] <= byte_r;
    if (cmd.commit && len_we)  len_mem[head_r]   <= fill_inc;
    if (cmd.issue_rd) begin
      rd_byte_r <= byte_mem[rd_addr];
      rd_len_r  <= len_mem[tail_r];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sink_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      fill_r      <= '0;
      send_r      <= '0;
      disc_r      <= 1'b0;
      drop_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) sink_r <= cfg_wr_data;
      if (cmd.commit) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
        fill_r <= fill_nxt;
        send_r <= send_nxt;
        disc_r <= disc_nxt;
        drop_r <= drop_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_tx_r   <= res_tx_nxt;
      res_log_r  <= res_log_nxt;
      res_byte_r <= res_byte_nxt;
      res_st_r   <= res_st_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_valid        = res_tx_r;
  assign out_log_valid       = res_log_r;
  assign out_out_byte        = res_byte_r;
  assign out_status          = res_st_r;
  assign out_queued_messages = 7'(cnt_r);
  assign out_dropped_total   = drop_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOTS_C)
    else $error("committed count beyond slot count");

  a_send_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (send_r != '0) |-> (cnt_r != '0))
    else $error("send offset set with empty queue");

  a_one_sink: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_tx_r && res_log_r))
    else $error("byte routed to both UART and log");

endmodule

FILE: design/message_slot_tx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_slot_tx_queue: ring of message slots feeding a UART transmitter
// out_valid rises when an append commits from the execute step, or when a
// transmit commits from the read step (tail read is registered before the
// result is built). No new item is taken until the current one commits,
// and a full result register stalls the commit in either step.
// Reset (rst_n, synchronous, low): pointers, counters and mode cleared;
// slot contents are not cleared, no clearing pass.
// ----------------------------------------------------------------------------
module message_slot_tx_queue #(
  parameter int SLOTS   = 64,
  parameter int MSG_MAX = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_write,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic        out_log_valid,
  output logic [7:0]  out_out_byte,
  output logic [1:0]  out_status,
  output logic [6:0]  out_queued_messages,
  output logic [31:0] out_dropped_total
);
  import mstq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mstq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mstq_dpath #(
    .SLOTS   (SLOTS),
    .MSG_MAX (MSG_MAX)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_opcode           (in_opcode),
    .in_data_byte        (in_data_byte),
    .in_end_of_write     (in_end_of_write),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_log_valid       (out_log_valid),
    .out_out_byte        (out_out_byte),
    .out_status          (out_status),
    .out_queued_messages (out_queued_messages),
    .out_dropped_total   (out_dropped_total)
  );

endmodule

FILE: sim/message_slot_tx_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_slot_tx_queue_tb: self-checking bench for the message slot TX queue
// A driver and a monitor push and collect beats with random idle gaps on
// both sides. Every accepted input beat is run through a local model of the
// slot ring, and each result beat is checked against the oldest prediction.
// Covers short and long writes, a full ring with drops and discards, and
// switching the log sink on and off while slots are queued.
// ----------------------------------------------------------------------------
module message_slot_tx_queue_tb;
  import mstq_pkg::*;

  localparam int SLOT_COUNT    = 64;
  localparam int MSG_BYTES     = 96;
  localparam int SETTLE_CYCLES = 8;     // margin beyond the transmit latency
  localparam int HOLD_AT       = 140;   // accepted beats before the long stall
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;  // cycles without any beat

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       eow;
  } queue_item_t;

  typedef struct packed {
    logic        tx;
    logic        lg;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [6:0]  queued;
    logic [31:0] dropped;
  } tx_beat_t;

  // DUT ports
  logic        clk;
  logic        rst_n           = 1'b0;
  logic        cfg_wr_en       = 1'b0;
  logic        cfg_wr_data     = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        in_opcode       = 1'b0;
  logic [7:0]  in_data_byte    = 8'h00;
  logic        in_end_of_write = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic        out_tx_valid;
  logic        out_log_valid;
  logic [7:0]  out_out_byte;
  logic [1:0]  out_status;
  logic [6:0]  out_queued_messages;
  logic [31:0] out_dropped_total;

  // Stimulus and scoreboard
  queue_item_t pending_items[$];
  tx_beat_t    expected_beats[$];
  queue_item_t offered;
  tx_beat_t    got_beat;
  tx_beat_t    want_beat;
  int          items_queued   = 0;
  int          items_accepted = 0;
  int          results_seen   = 0;
  int          err_count      = 0;
  int          send_wait      = 0;
  int          recv_wait      = 0;
  int          stall_cycles   = 0;
  int          n_tx_beats     = 0;
  int          n_log_beats    = 0;
  int          n_drops        = 0;
  int          n_discards     = 0;
  int          n_empty        = 0;
  logic        steady         = 1'b0;
  logic        hold_results   = 1'b0;

  // Model of the slot ring
  logic [7:0]  slot_mem [SLOT_COUNT][MSG_BYTES];
  int unsigned chunk_len [SLOT_COUNT];
  int unsigned head_idx   = 0;
  int unsigned tail_idx   = 0;
  int unsigned committed  = 0;
  int unsigned fill_pos   = 0;
  int unsigned send_pos   = 0;
  logic        discarding = 1'b0;
  logic [31:0] drop_cnt   = '0;
  logic        log_mode   = 1'b0;

  message_slot_tx_queue #(
    .SLOTS   (SLOT_COUNT),
    .MSG_MAX (MSG_BYTES)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_data_byte        (in_data_byte),
    .in_end_of_write     (in_end_of_write),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_log_valid       (out_log_valid),
    .out_out_byte        (out_out_byte),
    .out_status          (out_status),
    .out_queued_messages (out_queued_messages),
    .out_dropped_total   (out_dropped_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the ring model by one accepted beat, return the expected result
  function automatic tx_beat_t predict_tx_beat(queue_item_t it);
    tx_beat_t r;
    r = '0;
    if (it.op == OP_APPEND) begin
      if (log_mode) begin
        r.lg   = 1'b1;
        r.data = it.data;
      end else if (discarding) begin
        if (it.eow) discarding = 1'b0;
        r.status = STAT_DISCARD;
      end else if (fill_pos == 0 && committed >= SLOT_COUNT) begin
        // ring full at chunk start: count once, skip rest of the write
        drop_cnt   = drop_cnt + 1;
        discarding = !it.eow;
        r.status   = STAT_DROP;
      end else begin
        slot_mem[head_idx][fill_pos] = it.data;
        fill_pos++;
        if (fill_pos >= MSG_BYTES || it.eow) begin
          chunk_len[head_idx] = fill_pos;
          head_idx  = (head_idx + 1) % SLOT_COUNT;
          committed++;
          fill_pos  = 0;
        end
        r.status = STAT_OK;
      end
    end else if (committed == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      if (send_pos < chunk_len[tail_idx]) begin
        r.tx   = 1'b1;
        r.data = slot_mem[tail_idx][send_pos];
        send_pos++;
      end else begin
        r.status = STAT_EMPTY;
      end
      // retire the slot once its last byte is out
      if (send_pos >= chunk_len[tail_idx]) begin
        tail_idx = (tail_idx + 1) % SLOT_COUNT;
        committed--;
        send_pos = 0;
      end
    end
    r.queued  = committed[6:0];
    r.dropped = drop_cnt;
    return r;
  endfunction

  // Idle cycles before the next beat on either side
  function automatic int pick_wait();
    if (steady || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_beats.push_back(predict_tx_beat(offered));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered = pending_items.pop_front();
          in_opcode       <= offered.op;
          in_data_byte    <= offered.data;
          in_end_of_write <= offered.eow;
          in_valid        <= 1'b1;
          send_wait = pick_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_beat = {out_tx_valid, out_log_valid, out_out_byte, out_status,
                    out_queued_messages, out_dropped_total};
        results_seen++;
        case (out_status)
          STAT_DROP:    n_drops++;
          STAT_DISCARD: n_discards++;
          STAT_EMPTY:   n_empty++;
          default: begin
            if (out_tx_valid) n_tx_beats++;
            if (out_log_valid) n_log_beats++;
          end
        endcase
        if (expected_beats.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result beat with nothing expected: tx=%b log=%b byte=%h st=%0d",
                     $realtime, got_beat.tx, got_beat.lg, got_beat.data, got_beat.status);
        end else begin
          want_beat = expected_beats.pop_front();
          if (got_beat.tx !== want_beat.tx || got_beat.lg !== want_beat.lg ||
              got_beat.data !== want_beat.data || got_beat.status !== want_beat.status ||
              got_beat.queued !== want_beat.queued ||
              got_beat.dropped !== want_beat.dropped) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: beat %0d mismatch", $realtime, results_seen);
              $display("  expected tx=%b log=%b byte=%h st=%0d queued=%0d dropped=%0d",
                       want_beat.tx, want_beat.lg, want_beat.data, want_beat.status,
                       want_beat.queued, want_beat.dropped);
              $display("  actual   tx=%b log=%b byte=%h st=%0d queued=%0d dropped=%0d",
                       got_beat.tx, got_beat.lg, got_beat.data, got_beat.status,
                       got_beat.queued, got_beat.dropped);
            end
          end
        end
        recv_wait = pick_wait();
      end
      if (hold_results) begin
        out_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver stall so the block backs up into its input
  initial begin
    while (items_accepted < HOLD_AT) @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  // Watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d predictions open",
               STALL_LIMIT, expected_beats.size());
      $display("[message_slot_tx_queue] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_item(logic op, logic [7:0] d, logic e);
    pending_items.push_back({op, d, e});
    items_queued++;
  endtask

  // One well-formed write of n bytes, last one flagged
  task automatic add_write(int n);
    for (int i = 0; i < n; i++)
      add_item(OP_APPEND, 8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // Transmit-ready beats; data and end flag carry random junk
  task automatic add_tx(int n);
    for (int i = 0; i < n; i++)
      add_item(OP_TX_READY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++)
      add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
  endtask

  // Mix of writes, transmit runs and stray beats
  task automatic add_bursts(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) add_write($urandom_range(1, 6));
      else if (pick < 9) add_tx($urandom_range(1, 8));
      else add_noise($urandom_range(1, 3));
    end
  endtask

  // Wait until every queued beat is in and every result is back
  task automatic settle();
    do @(posedge clk);
    while (items_accepted != items_queued || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sink(logic to_log);
    cfg_wr_data <= to_log;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    log_mode = to_log;
  endtask

  // Stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_sink(1'b0);

    // directed: empty ring, single and two-byte writes, field extremes
    add_item(OP_TX_READY, 8'h00, 1'b0);
    add_item(OP_APPEND,   8'h00, 1'b1);
    add_item(OP_TX_READY, 8'h00, 1'b0);
    add_item(OP_TX_READY, 8'h00, 1'b0);
    add_item(OP_APPEND,   8'hFF, 1'b0);
    add_item(OP_APPEND,   8'h80, 1'b1);
    add_item(OP_APPEND,   8'h01, 1'b1);
    add_tx(3);
    add_item(OP_TX_READY, 8'hFF, 1'b1);
    // leave one slot queued and a chunk open across the log phase
    add_item(OP_APPEND,   8'h55, 1'b1);
    add_item(OP_APPEND,   8'h3C, 1'b0);
    settle();
    set_sink(1'b1);
    add_item(OP_APPEND,   8'hFF, 1'b0);
    add_item(OP_APPEND,   8'h00, 1'b1);
    add_item(OP_TX_READY, 8'h00, 1'b0);
    add_item(OP_TX_READY, 8'h00, 1'b0);
    settle();
    set_sink(1'b0);
    add_item(OP_APPEND,   8'hC3, 1'b1);
    add_tx(3);

    // random mix, then enough short writes to fill the ring and drop
    add_bursts(20);
    for (int i = 0; i < 75; i++) add_write($urandom_range(1, 3));
    // a write cut off by a drop and left discarding into the log phase
    for (int i = 0; i < 3; i++) add_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b0);
    settle();

    // log sink with the ring still loaded, back to back
    set_sink(1'b1);
    steady <= 1'b1;
    add_noise(30);
    settle();

    // back to the queue: finish the discard, then drain
    set_sink(1'b0);
    add_write($urandom_range(2, 5));
    add_tx(120);
    settle();
    steady <= 1'b0;

    // one write long enough to split into chunks, then more mix
    add_write($urandom_range(97, 160));
    add_bursts(5);
    settle();

    $display("run: %0d beats in, %0d checked; %0d UART bytes, %0d log bytes",
             items_accepted, results_seen, n_tx_beats, n_log_beats);
    $display("run: %0d chunks dropped, %0d bytes discarded, %0d empty polls",
             n_drops, n_discards, n_empty);
    if (err_count == 0) begin
      $display("[message_slot_tx_queue] OK");
    end else begin
      $display("%0d failing beats", err_count);
      $display("[message_slot_tx_queue] ERROR");
    end
    $finish;
  end

endmodule
